// ===== hdl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, types and helpers for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int NUM_SLOTS = 8192;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = NUM_SLOTS / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_W    = 13;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [BIT_W-1:0]     bitpos_t;
    typedef logic [SLOT_W-1:0]    slot_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FULL = 1'b1
    } status_t;

    // RAM access issued by the controller
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
    } ram_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        slot_t   slot;
        status_t status;
    } result_t;

    // Priority encoder: position of the lowest clear bit
    function automatic bitpos_t lowest_clear(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = bitpos_t'(i);
            end
        end
        return pos;
    endfunction

    // word index * WORD_BITS + bit, kept to the slot width
    function automatic slot_t make_slot(input idx_t idx, input bitpos_t pos);
        logic [31:0] tmp;
        tmp = 32'(idx) * 32'(WORD_BITS) + 32'(pos);
        return tmp[SLOT_W-1:0];
    endfunction

endpackage

// ===== hdl/bsa_req_if.sv =====
// ----------------------------------------------------------------------------
// bsa_req_if
// Request channel: valid/ready with opcode and slot to release.
// ----------------------------------------------------------------------------
interface bsa_req_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    bsa_pkg::slot_t       release_slot;

    modport source (output valid, output opcode, output release_slot, input ready);
    modport sink   (input valid, input opcode, input release_slot, output ready);
endinterface

// ===== hdl/bsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Result channel: valid/ready with granted slot and status.
// ----------------------------------------------------------------------------
interface bsa_rsp_if;
    logic                 valid;
    logic                 ready;
    bsa_pkg::slot_t       granted_slot;
    logic                 status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

// ===== hdl/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// bsa_ram
// Simple dual-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsa_ctrl
// Scan / read-modify-write sequencer over the bitmap RAM.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    bsa_req_if.sink            req,
    output bsa_pkg::ram_req_t  ram_req,
    input  bsa_pkg::word_t     ram_rd_data,
    output bsa_pkg::result_t   res,
    output logic               res_valid,
    input  logic               res_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_REL  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    bsa_pkg::idx_t              scan_idx_reg, scan_idx_next;
    bsa_pkg::idx_t              rel_idx_reg, rel_idx_next;
    bsa_pkg::bitpos_t           rel_bit_reg, rel_bit_next;
    logic                       rel_ok_reg, rel_ok_next;
    bsa_pkg::result_t           res_reg, res_next;
    logic [bsa_pkg::MAP_WORDS-1:0] valid_reg;
    logic                       rd_valid_reg;

    bsa_pkg::word_t             word_q;
    bsa_pkg::bitpos_t           free_pos;
    logic                       word_free;
    logic                       last_word;
    logic [31:0]                rel_word;

    // words never written read as all free
    assign word_q    = rd_valid_reg ? ram_rd_data : '0;
    assign word_free = (word_q != '1);
    assign free_pos  = bsa_pkg::lowest_clear(word_q);
    assign last_word = (scan_idx_reg == bsa_pkg::IDX_W'(bsa_pkg::MAP_WORDS - 1));
    assign rel_word  = 32'(req.release_slot >> bsa_pkg::BIT_W);

    assign req.ready = (state_reg == S_IDLE);
    assign res       = res_reg;
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        rel_idx_next  = rel_idx_reg;
        rel_bit_next  = rel_bit_reg;
        rel_ok_next   = rel_ok_reg;
        res_next      = res_reg;
        ram_req       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == bsa_pkg::OP_ALLOC)
                    begin
                        scan_idx_next   = '0;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        rel_idx_next    = rel_word[bsa_pkg::IDX_W-1:0];
                        rel_bit_next    = req.release_slot[bsa_pkg::BIT_W-1:0];
                        rel_ok_next     = (rel_word < 32'(bsa_pkg::MAP_WORDS));
                        res_next.slot   = req.release_slot;
                        res_next.status = bsa_pkg::ST_OK;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rel_word[bsa_pkg::IDX_W-1:0];
                        state_next      = S_REL;
                    end
                end
            end
            S_SCAN:
            begin
                if (word_free)
                begin
                    // w | (w + 1) sets the lowest clear bit
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = scan_idx_reg;
                    ram_req.wr_data = word_q | (word_q + bsa_pkg::word_t'(1));
                    res_next.slot   = bsa_pkg::make_slot(scan_idx_reg, free_pos);
                    res_next.status = bsa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else if (last_word)
                begin
                    res_next.slot   = '0;
                    res_next.status = bsa_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_idx_next   = scan_idx_reg + bsa_pkg::idx_t'(1);
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = scan_idx_reg + bsa_pkg::idx_t'(1);
                end
            end
            S_REL:
            begin
                if (rel_ok_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = rel_idx_reg;
                    ram_req.wr_data = word_q & ~(bsa_pkg::word_t'(1) << rel_bit_reg);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_req.wr_en)
            begin
                valid_reg[ram_req.wr_addr] <= 1'b1;
            end
            if (ram_req.rd_en)
            begin
                rd_valid_reg <= valid_reg[ram_req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        rel_idx_reg  <= rel_idx_next;
        rel_bit_reg  <= rel_bit_next;
        rel_ok_reg   <= rel_ok_next;
        res_reg      <= res_next;
    end

    // RAM is written only while an access is being resolved
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> (state_reg == S_SCAN || state_reg == S_REL))
        else $error("bitmap write outside scan/release");

    // a new request always starts work in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_SCAN || state_reg == S_REL))
        else $error("accepted request did not start");

    // a full map reports slot zero
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == bsa_pkg::ST_FULL) |-> (res.slot == '0))
        else $error("full status with non-zero slot");

    // scan advances by exactly one word past a full word
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !word_free && !last_word)
        |=> (state_reg == S_SCAN && scan_idx_reg == $past(scan_idx_reg) + 1'b1))
        else $error("scan index skipped");

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Sequence: allocate goes IDLE, SCAN (word 0 up to the first word with a clear
//   bit, or the last word when full), DONE; release goes IDLE, REL, DONE.
// Throughput: one request at a time, each bounded in length by the
//   one-word-per-cycle scan through the bitmap RAM read port.
// Reset: asynchronous; all slots free at once via per-word valid flags, no
//   clearing pass, so a request can be taken on the first cycle after reset.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator (
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);

    // Bitmap RAM: one bit per slot, set means in use.
    bsa_pkg::ram_req_t ram_req;
    bsa_pkg::word_t    ram_rd_data;

    // Result from the sequencer, held until the output register is free.
    bsa_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;

    // Output register: frees the sequencer while a result waits downstream.
    logic              out_valid_reg, out_valid_next;
    bsa_pkg::result_t  out_res_reg, out_res_next;

    bsa_ram #(
        .DEPTH (bsa_pkg::MAP_WORDS),
        .WIDTH (bsa_pkg::WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data)
    );

    bsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    // Take a new result when empty or when the current one leaves this cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_slot = out_res_reg.slot;
    assign rsp.status       = out_res_reg.status;

endmodule
